// File: sv/prc_pkg.sv
package prc_pkg;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t p2;
    byte_t p1;
    byte_t p0;
  } px_t;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  localparam byte_t BIAS = 8'h80;

  // Paeth with left first, then top-left if strictly closer than top
  function automatic byte_t paeth(byte_t l, byte_t t, byte_t c);
    logic signed [9:0] dl;
    logic signed [9:0] dt;
    logic signed [9:0] s;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    dl = $signed({2'b00, l}) - $signed({2'b00, c});
    dt = $signed({2'b00, t}) - $signed({2'b00, c});
    s  = dl + dt;
    pa = dt[9] ? 10'(-dt) : 10'(dt);
    pb = dl[9] ? 10'(-dl) : 10'(dl);
    pc = s[9]  ? 10'(-s)  : 10'(s);
    if (pc >= pa && pb >= pa) begin
      return l;
    end else if (pc < pb) begin
      return c;
    end
    return t;
  endfunction

endpackage

// File: sv/prc_in_if.sv
interface prc_in_if import prc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t residual_plane0;
  byte_t residual_plane1;
  byte_t residual_plane2;

  modport source (output valid, output residual_plane0, output residual_plane1,
                  output residual_plane2, input ready);
  modport sink   (input valid, input residual_plane0, input residual_plane1,
                  input residual_plane2, output ready);
endinterface

// File: sv/prc_out_if.sv
interface prc_out_if import prc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte0;
  byte_t out_byte1;
  byte_t out_byte2;
  logic  last_pixel;

  modport source (output valid, output out_byte0, output out_byte1,
                  output out_byte2, output last_pixel, input ready);
  modport sink   (input valid, input out_byte0, input out_byte1,
                  input out_byte2, input last_pixel, output ready);
endinterface

// File: sv/paeth_plane_reconstruct_color.sv
// Paeth plane reconstruction with reversible colour transform.
// in_i carries one pixel request per transfer in raster order: three residual
// bytes, one per plane. out_o returns one result per pixel: r+g, g, b+g and a
// flag on the final pixel of the image. Both channels use valid/ready; a
// transfer happens on a rising edge with both high.
// image_width and image_height are set through cfg_we_i/cfg_idx_i/cfg_data_i
// (index 0 width, index 1 height), by the user only while the block is idle;
// the block does not enforce this. Throughput is one pixel per cycle while
// out_o does not stall. A result reaches out_o through the predict-stage and
// output registers: the line store is read at the edge that takes the request
// (registered read), and the predict stage runs the three Paeth predictors
// against the left and top-left pixel registers and the colour transform into
// the output register; the left-pixel feedback closes within that stage.
// A stall on out_o holds the output register and the pixel in the predict
// stage; in_i drops ready only while both are full and the output is not
// taken. Reset empties the pipeline, clears the counters and neighbour
// registers and loads width 640, height 480. The line store is not cleared;
// each entry is written by the first row before any later row reads it.
module paeth_plane_reconstruct_color import prc_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  prc_in_if.sink              in_i,
  prc_out_if.source           out_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [12:0]   cfg_w_q;
  logic [15:0]   cfg_h_q;
  logic [CW-1:0] col_cnt_q;
  logic [15:0]   row_cnt_q;

  logic [31:0]   w_ext;
  logic [31:0]   w_clamp;
  logic [CW:0]   w_eff;
  logic [CW:0]   w_m1;
  logic [15:0]   h_eff;
  logic [CW-1:0] col_s0;
  logic          row_end_s0;
  logic          last_s0;
  logic          first_s0;
  logic          in_acc;

  logic          s1_valid_q;
  logic [CW-1:0] col_s1_q;
  logic          first_s1_q;
  logic          last_s1_q;
  px_t           res_s1_q;
  logic          s1_adv;

  px_t           row_store [MAX_WIDTH];
  px_t           rdata_q;
  px_t           fwd_data_q;
  logic          fwd_q;
  px_t           top;
  px_t           left_q;
  px_t           ul_q;
  px_t           value;

  byte_t         sb;
  byte_t         sr;
  logic signed [8:0] sum;
  logic signed [8:0] quarter;
  byte_t         g;

  logic          out_valid_q;
  byte_t         ob0_q;
  byte_t         ob1_q;
  byte_t         ob2_q;
  logic          olast_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= WIDTH_RESET;
      cfg_h_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i[12:0];
        CFG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // position of the incoming pixel
  always_comb begin
    w_ext = {19'b0, cfg_w_q};
    if (w_ext == 32'd0) begin
      w_clamp = 32'd1;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    w_eff = w_clamp[CW:0];
    w_m1  = w_eff - (CW+1)'(1);
    h_eff = (cfg_h_q == 16'd0) ? 16'd1 : cfg_h_q;
    col_s0 = ({1'b0, col_cnt_q} >= w_eff) ? w_m1[CW-1:0] : col_cnt_q;
    row_end_s0 = ({1'b0, col_s0} + (CW+1)'(1)) >= w_eff;
    last_s0 = row_end_s0 && (({1'b0, row_cnt_q} + 17'd1) >= {1'b0, h_eff});
    first_s0 = (row_cnt_q == 16'd0) || (col_s0 == '0);
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      if (last_s0) begin
        col_cnt_q <= '0;
        row_cnt_q <= '0;
      end else if (row_end_s0) begin
        col_cnt_q <= '0;
        row_cnt_q <= row_cnt_q + 16'd1;
      end else begin
        col_cnt_q <= col_s0 + CW'(1);
      end
    end
  end

  // predict stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_s1_q   <= col_s0;
      first_s1_q <= first_s0;
      last_s1_q  <= last_s0;
      res_s1_q   <= '{p2: in_i.residual_plane2, p1: in_i.residual_plane1,
                      p0: in_i.residual_plane0};
    end
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_store[col_s1_q] <= value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= row_store[col_s0];
    end
  end

  // single-column images read the entry being written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_adv && (col_s1_q == col_s0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= value;
    end
  end

  assign top = fwd_q ? fwd_data_q : rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      ul_q   <= '0;
    end else if (s1_adv) begin
      left_q <= value;
      ul_q   <= top;
    end
  end

  always_comb begin
    if (first_s1_q) begin
      value = res_s1_q;
    end else begin
      value.p0 = res_s1_q.p0 + paeth(left_q.p0, top.p0, ul_q.p0) + BIAS;
      value.p1 = res_s1_q.p1 + paeth(left_q.p1, top.p1, ul_q.p1) + BIAS;
      value.p2 = res_s1_q.p2 + paeth(left_q.p2, top.p2, ul_q.p2) + BIAS;
    end
    sb      = value.p2 ^ BIAS;
    sr      = value.p1 ^ BIAS;
    sum     = $signed({sb[7], sb}) + $signed({sr[7], sr});
    quarter = sum >>> 2;
    g       = value.p0 - quarter[7:0];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ob0_q   <= sr + g;
      ob1_q   <= g;
      ob2_q   <= sb + g;
      olast_q <= last_s1_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte0  = ob0_q;
  assign out_o.out_byte1  = ob1_q;
  assign out_o.out_byte2  = ob2_q;
  assign out_o.last_pixel = olast_q;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_s0 |=> col_cnt_q == '0 && row_cnt_q == 16'd0)
    else $error("counters not cleared after last pixel");

  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && row_end_s0 && !last_s0 |=>
      col_cnt_q == '0 && row_cnt_q == $past(row_cnt_q) + 16'd1)
    else $error("row counter did not advance at row end");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(col_s1_q))
    else $error("stalled pixel lost from predict stage");

endmodule
